/* design/mlnps_pkg.sv */
`timescale 1ns / 1ps

package mlnps_pkg;

    // Event codes carried on the mode field.
    localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
    localparam logic [1:0] MODE_ALL_OFF  = 2'd2;
    localparam logic [1:0] MODE_OTHER    = 2'd3;

    localparam int MODE_W  = 2;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int COUNT_W = 5;

    // A2, the pitch target after reset.
    localparam logic [NOTE_W-1:0] RESET_TARGET = 7'd45;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic apply;
    } cmd_t;

endpackage

/* design/mlnps_ctrl.sv */
`timescale 1ns / 1ps

module mlnps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    output mlnps_pkg::cmd_t  cmd
);
    import mlnps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                busy       = 1'b1;
                cmd.apply  = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

/* design/mlnps_datapath.sv */
`timescale 1ns / 1ps

module mlnps_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mlnps_pkg::cmd_t              cmd,
    input  logic [mlnps_pkg::MODE_W-1:0] mode,
    input  logic [mlnps_pkg::NOTE_W-1:0] note,
    input  logic [mlnps_pkg::VEL_W-1:0]  velocity,
    input  logic                         voice_silent,
    output logic                         gate,
    output logic [mlnps_pkg::NOTE_W-1:0] target_note,
    output logic                         snap_pitch,
    output logic [mlnps_pkg::VEL_W-1:0]  held_velocity,
    output logic [mlnps_pkg::COUNT_W-1:0] stack_count
);
    import mlnps_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Cell 0 is the newest note; cells below count_reg are valid.
    logic [NOTE_W-1:0] entry_reg  [STACK_DEPTH];
    logic [NOTE_W-1:0] entry_next [STACK_DEPTH];
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              gate_reg;
    logic              gate_next;
    logic [NOTE_W-1:0] target_reg;
    logic [NOTE_W-1:0] target_next;
    logic [VEL_W-1:0]  last_vel_reg;
    logic [VEL_W-1:0]  last_vel_next;
    logic              snap_reg;
    logic              snap_next;

    // Latched event.
    logic [MODE_W-1:0] mode_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;
    logic              silent_reg;

    logic [STACK_DEPTH-1:0] match;
    logic [STACK_DEPTH-1:0] close_up;
    logic                   drop_event;

    // The stack never holds two copies of a note, so at most one cell matches.
    // Every cell from the match toward the bottom moves up one place.
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            match[i] = (count_reg > CW'(i)) && (entry_reg[i] == note);
        end
        close_up[0] = match[0];
        for (int i = 1; i < STACK_DEPTH; i++)
        begin
            close_up[i] = close_up[i-1] | match[i];
        end
        drop_event = (mode == MODE_NOTE_ON) || (mode == MODE_NOTE_OFF);
    end

    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        count_next    = count_reg;
        gate_next     = gate_reg;
        target_next   = target_reg;
        last_vel_next = last_vel_reg;
        snap_next     = snap_reg;

        if (cmd.capture && drop_event)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                if (close_up[i])
                begin
                    entry_next[i] = entry_reg[(i < STACK_DEPTH - 1) ? i + 1 : i];
                end
            end
            if (close_up[STACK_DEPTH-1])
            begin
                count_next = count_reg - CW'(1);
            end
        end

        if (cmd.apply)
        begin
            snap_next = 1'b0;
            case (mode_reg)
                MODE_NOTE_ON, MODE_NOTE_OFF:
                begin
                    if ((mode_reg == MODE_NOTE_ON) && (vel_reg != '0))
                    begin
                        if (count_reg < CW'(STACK_DEPTH))
                        begin
                            entry_next[0] = note_reg;
                            for (int i = 1; i < STACK_DEPTH; i++)
                            begin
                                entry_next[i] = entry_reg[i-1];
                            end
                            count_next = count_reg + CW'(1);
                        end
                        target_next   = note_reg;
                        snap_next     = !gate_reg && silent_reg;
                        last_vel_next = vel_reg;
                        gate_next     = 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        target_next = entry_reg[0];
                        gate_next   = 1'b1;
                    end
                    else
                    begin
                        gate_next = 1'b0;
                    end
                end
                MODE_ALL_OFF:
                begin
                    count_next = '0;
                    gate_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            entry_reg[i] <= entry_next[i];
        end
        if (cmd.capture)
        begin
            mode_reg   <= mode;
            note_reg   <= note;
            vel_reg    <= velocity;
            silent_reg <= voice_silent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            gate_reg     <= 1'b0;
            target_reg   <= RESET_TARGET;
            last_vel_reg <= '0;
            snap_reg     <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            gate_reg     <= gate_next;
            target_reg   <= target_next;
            last_vel_reg <= last_vel_next;
            snap_reg     <= snap_next;
        end
    end

    assign gate          = gate_reg;
    assign target_note   = target_reg;
    assign snap_pitch    = snap_reg;
    assign held_velocity = last_vel_reg;
    assign stack_count   = COUNT_W'(count_reg);

endmodule

/* design/mono_last_note_priority_stack.sv */
`timescale 1ns / 1ps

// Channel   Handshake             Ports
// event     start, busy           mode, note, velocity, voice_silent
// result    done (one-cycle)      gate, target_note, snap_pitch, held_velocity, stack_count
//
// An item is taken when start is high and busy is low. The capture step removes the
// event's note from the cell chain; the apply step that follows pushes the note or picks
// the new target, and done pulses in the cycle after that.
// A new item may be started in the same cycle that done is high.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is asynchronous and active low; it empties the stack, closes the gate and sets
// the target to note 45.

module mono_last_note_priority_stack #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mlnps_pkg::MODE_W-1:0]  mode,
    input  logic [mlnps_pkg::NOTE_W-1:0]  note,
    input  logic [mlnps_pkg::VEL_W-1:0]   velocity,
    input  logic                          voice_silent,
    output logic                          done,
    output logic                          gate,
    output logic [mlnps_pkg::NOTE_W-1:0]  target_note,
    output logic                          snap_pitch,
    output logic [mlnps_pkg::VEL_W-1:0]   held_velocity,
    output logic [mlnps_pkg::COUNT_W-1:0] stack_count
);
    import mlnps_pkg::*;

    cmd_t cmd;

    // The controller sequences the capture and apply steps of each item.
    mlnps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the note cell chain and the voice state. Results come
    // straight from its state registers. The stack count already moves at the edge
    // that takes the item, and everything has settled by the end of the apply cycle,
    // so the ports are only meaningful while done is high.
    mlnps_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .note          (note),
        .velocity      (velocity),
        .voice_silent  (voice_silent),
        .gate          (gate),
        .target_note   (target_note),
        .snap_pitch    (snap_pitch),
        .held_velocity (held_velocity),
        .stack_count   (stack_count)
    );

endmodule

/* bench/tb_mono_last_note_priority_stack.sv */
`timescale 1ns / 1ps

// This bench checks the last-note-priority key tracker.
// A clocked driver feeds note events from a queue that the initial block fills.
// A clocked monitor compares every done strobe with the oldest predicted voice state.
module tb_mono_last_note_priority_stack;

    import mlnps_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 900;
    // The last items of the random part go out back to back, with no idle bursts.
    localparam int CALM_TAIL    = 150;
    // Cycles with no accepted item and no result before the run is declared hung.
    localparam int STALL_LIMIT  = 400;
    // Cycles to wait after the last result, so that a stray extra result is caught.
    localparam int DRAIN_CYCLES = 10;

    // One note event, plus the number of idle cycles the driver waits before offering it.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  velocity;
        logic              voice_silent;
        int unsigned       idle_before;
    } note_event_t;

    // The voice control state reported after one event.
    typedef struct packed {
        logic               gate;
        logic [NOTE_W-1:0]  target_note;
        logic               snap_pitch;
        logic [VEL_W-1:0]   held_velocity;
        logic [COUNT_W-1:0] stack_count;
    } voice_state_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [MODE_W-1:0]  mode = MODE_OTHER;
    logic [NOTE_W-1:0]  note = '0;
    logic [VEL_W-1:0]   velocity = '0;
    logic               voice_silent = 1'b0;
    logic               busy;
    logic               done;
    logic               gate;
    logic [NOTE_W-1:0]  target_note;
    logic               snap_pitch;
    logic [VEL_W-1:0]   held_velocity;
    logic [COUNT_W-1:0] stack_count;

    note_event_t  pending_events[$];
    voice_state_t expected_states[$];
    note_event_t  in_flight;
    voice_state_t want;

    // The bench's own copy of the tracker state. The held stack keeps the newest note last.
    logic [NOTE_W-1:0] held_stack[$];
    logic              model_gate = 1'b0;
    logic [NOTE_W-1:0] model_target = RESET_TARGET;
    logic [VEL_W-1:0]  model_velocity = '0;

    int errors = 0;
    int stall_cycles = 0;
    bit idle_enabled = 1'b1;
    bit quiet_tail = 1'b0;

    mono_last_note_priority_stack #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .note(note),
        .velocity(velocity),
        .voice_silent(voice_silent),
        .done(done),
        .gate(gate),
        .target_note(target_note),
        .snap_pitch(snap_pitch),
        .held_velocity(held_velocity),
        .stack_count(stack_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Removes every copy of a note from the held stack and keeps the order of the rest.
    function automatic void drop_from_stack(input logic [NOTE_W-1:0] pitch);
        logic [NOTE_W-1:0] kept[$];
        foreach (held_stack[i])
        begin
            if (held_stack[i] != pitch)
                kept = {kept, held_stack[i]};
        end
        held_stack = kept;
    endfunction

    // Applies one accepted event to the bench's tracker state and queues the state that
    // the block should report for it.
    function automatic void predict_voice(input note_event_t ev);
        voice_state_t s;
        s.snap_pitch = 1'b0;
        if (ev.mode == MODE_NOTE_ON && ev.velocity != '0)
        begin
            // A repeated key moves to the top. When the stack is full the key is not
            // stored, but it still takes over the pitch and opens the gate.
            drop_from_stack(ev.note);
            if (held_stack.size() < DEPTH)
                held_stack = {held_stack, ev.note};
            model_target = ev.note;
            // A fresh note on a silent voice jumps straight to its pitch.
            if (!model_gate && ev.voice_silent)
                s.snap_pitch = 1'b1;
            model_velocity = ev.velocity;
            model_gate = 1'b1;
        end
        else if (ev.mode == MODE_NOTE_OFF || ev.mode == MODE_NOTE_ON)
        begin
            // A note off, or a note on with zero velocity. Even when the key was not held,
            // a non-empty stack hands the pitch back to its newest key.
            drop_from_stack(ev.note);
            if (held_stack.size() != 0)
            begin
                model_target = held_stack[$];
                model_gate = 1'b1;
            end
            else
            begin
                model_gate = 1'b0;
            end
        end
        else if (ev.mode == MODE_ALL_OFF)
        begin
            // The target and the last velocity survive an all-notes-off.
            held_stack.delete();
            model_gate = 1'b0;
        end
        s.gate = model_gate;
        s.target_note = model_target;
        s.held_velocity = model_velocity;
        s.stack_count = COUNT_W'(held_stack.size());
        expected_states = {expected_states, s};
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Picks the idle time ahead of the next event. Idling comes in bursts and is switched
    // off for whole groups of items and for the tail of the run.
    function automatic int unsigned next_idle();
        if (quiet_tail || !idle_enabled || $urandom_range(0, 99) >= 30)
            return 0;
        return $urandom_range(1, 11);
    endfunction

    task automatic queue_event(input logic [MODE_W-1:0] m, input logic [NOTE_W-1:0] n,
                               input logic [VEL_W-1:0] v, input logic s);
        note_event_t ev;
        ev.mode = m;
        ev.note = n;
        ev.velocity = v;
        ev.voice_silent = s;
        ev.idle_before = next_idle();
        pending_events = {pending_events, ev};
    endtask

    // Driver. An item is taken at an edge where start is high and busy is low. Start then
    // either stays high with the next item or drops for an idle burst, with a single
    // assignment per edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_voice(in_flight);
            if (!start || !busy)
            begin
                if (pending_events.size() == 0)
                begin
                    start <= 1'b0;
                end
                else if (pending_events[0].idle_before != 0)
                begin
                    pending_events[0].idle_before = pending_events[0].idle_before - 1;
                    start <= 1'b0;
                end
                else
                begin
                    in_flight = pending_events.pop_front();
                    start <= 1'b1;
                    mode <= in_flight.mode;
                    note <= in_flight.note;
                    velocity <= in_flight.velocity;
                    voice_silent <= in_flight.voice_silent;
                end
            end
        end
    end

    // Monitor. The receiver cannot stall, so every done strobe is a result to check.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_states.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual gate %0d target %0d",
                         $time, gate, target_note);
                errors++;
            end
            else
            begin
                want = expected_states.pop_front();
                check_field("gate", want.gate, gate);
                check_field("target_note", want.target_note, target_note);
                check_field("snap_pitch", want.snap_pitch, snap_pitch);
                check_field("held_velocity", want.held_velocity, held_velocity);
                check_field("stack_count", want.stack_count, stack_count);
            end
        end
    end

    // Counts cycles in which neither an item nor a result is accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int produced;
        int group_len;
        int span;
        int base;
        int pick;
        logic [NOTE_W-1:0] pitch;

        // Directed part. A status query right after reset shows the reset state, then
        // the extreme keys exercise snapping, re-pressing a held key and release order.
        queue_event(MODE_OTHER, 7'd127, 7'd127, 1'b1);
        queue_event(MODE_NOTE_ON, 7'd0, 7'd127, 1'b1);
        queue_event(MODE_NOTE_ON, 7'd127, 7'd1, 1'b1);
        queue_event(MODE_NOTE_ON, 7'd0, 7'd64, 1'b0);
        // A zero-velocity note on releases a held key that is not the top one.
        queue_event(MODE_NOTE_ON, 7'd127, 7'd0, 1'b1);
        queue_event(MODE_NOTE_OFF, 7'd0, 7'd127, 1'b0);
        // Releasing a key on an empty stack keeps the gate closed.
        queue_event(MODE_NOTE_OFF, 7'd5, 7'd0, 1'b1);
        // Seventeen distinct keys: the last one does not fit but still sets the pitch.
        for (int i = 0; i <= DEPTH; i++)
            queue_event(MODE_NOTE_ON, NOTE_W'(10 + 7 * i), VEL_W'(20 + i), i == 0);
        // Releasing the key that was never stored falls back to the newest held key.
        queue_event(MODE_NOTE_OFF, NOTE_W'(10 + 7 * DEPTH), 7'd33, 1'b0);
        queue_event(MODE_ALL_OFF, 7'd85, 7'd42, 1'b1);

        // Random part, in groups. Each group plays over a key range of its own: narrow
        // ranges make releases hit held keys, wide ones fill the stack and add noise.
        produced = 0;
        while (produced < RANDOM_ITEMS)
        begin
            group_len = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0: span = 3;
                1: span = 8;
                2: span = 20;
                default: span = 127;
            endcase
            base = $urandom_range(0, 127 - span);
            idle_enabled = ($urandom_range(0, 9) < 7);
            for (int k = 0; k < group_len && produced < RANDOM_ITEMS; k++)
            begin
                quiet_tail = (produced >= RANDOM_ITEMS - CALM_TAIL);
                pick = $urandom_range(0, 99);
                pitch = NOTE_W'(base + $urandom_range(0, span));
                if (pick < 55)
                    queue_event(MODE_NOTE_ON, pitch, VEL_W'($urandom_range(1, 127)),
                                1'($urandom_range(0, 1)));
                else if (pick < 85)
                    queue_event(MODE_NOTE_OFF, pitch, VEL_W'($urandom_range(0, 127)),
                                1'($urandom_range(0, 1)));
                else if (pick < 90)
                    queue_event(MODE_NOTE_ON, pitch, '0, 1'($urandom_range(0, 1)));
                else if (pick < 95)
                    queue_event(MODE_ALL_OFF, NOTE_W'($urandom_range(0, 127)),
                                VEL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                else
                    queue_event(MODE_OTHER, NOTE_W'($urandom_range(0, 127)),
                                VEL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                produced++;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every event has gone in and every predicted state has come back.
        do
            @(negedge clk);
        while (pending_events.size() != 0 || start || expected_states.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
